FILE: rtl/csma_pkg.sv
// Shared types, constants and tables for the conic scatter matrix accumulator.
`timescale 1ns / 1ps

package csma_pkg;

  localparam int COORD_W     = 16;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int SQ_W        = 2 * DIFF_W;
  localparam int SUM_W       = 64;
  localparam int COUNT_W     = 15;
  localparam int NUM_SUMS    = 14;
  localparam int NUM_SLOTS   = 21;
  localparam int SLOT_W      = 5;
  localparam int SUM_IDX_W   = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_DATA_W   = 2 * COORD_W;
  localparam int OUT_DATA_W  = 72;

  localparam logic [COUNT_W-1:0]   MAX_POINTS = 15'd32767;
  localparam logic [CFG_IDX_W-1:0] REG_X_MEAN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MEAN = 1'd1;
  localparam logic [SLOT_W-1:0]    COUNT_SLOT = 5'd20;

  // Index of the sum that feeds each of the moment slots; some slots share a sum.
  localparam logic [SUM_IDX_W-1:0] SLOT_SOURCE [0:NUM_SLOTS-2] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5,
    4'd2, 4'd6, 4'd4, 4'd7, 4'd8,
    4'd9, 4'd7, 4'd10, 4'd11,
    4'd5, 4'd8, 4'd12,
    4'd11, 4'd13
  };

  typedef struct packed {
    logic load;
    logic square;
    logic cube;
    logic accum;
    logic advance;
  } csma_cmd_t;

  typedef struct packed {
    logic last_point;
    logic final_slot;
  } csma_status_t;

endpackage

FILE: rtl/csma_datapath.sv
// Datapath: mean subtraction, monomial products, moment sums and result selection.
`timescale 1ns / 1ps

module csma_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [csma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csma_pkg::COORD_W-1:0]   cfg_data,
  input  logic [csma_pkg::IN_DATA_W-1:0] in_data,
  input  logic                           in_last,
  input  csma_pkg::csma_cmd_t            cmd,
  output csma_pkg::csma_status_t         status,
  output logic [csma_pkg::SLOT_W-1:0]    entry_index,
  output logic [csma_pkg::SUM_W-1:0]     entry_value
);
  import csma_pkg::*;

  logic signed [COORD_W-1:0] x_mean;
  logic signed [COORD_W-1:0] y_mean;
  logic signed [DIFF_W-1:0]  dx;
  logic signed [DIFF_W-1:0]  dy;
  logic                      last_flag;
  logic signed [SQ_W-1:0]    x2;
  logic signed [SQ_W-1:0]    y2;
  logic signed [SQ_W-1:0]    xy;
  logic signed [DIFF_W-1:0]  dx_d;
  logic signed [DIFF_W-1:0]  dy_d;
  logic [SUM_W-1:0]          terms [NUM_SUMS];
  logic [SUM_W-1:0]          sums [NUM_SUMS];
  logic [COUNT_W-1:0]        point_count;
  logic [SLOT_W-1:0]         slot;

  logic signed [DIFF_W-1:0]        dx_in;
  logic signed [DIFF_W-1:0]        dy_in;
  logic signed [SQ_W+DIFF_W-1:0]   p_x3;
  logic signed [SQ_W+DIFF_W-1:0]   p_x2y;
  logic signed [SQ_W+DIFF_W-1:0]   p_xy2;
  logic signed [SQ_W+DIFF_W-1:0]   p_y3;
  logic signed [2*SQ_W-1:0]        p_x4;
  logic signed [2*SQ_W-1:0]        p_x3y;
  logic signed [2*SQ_W-1:0]        p_x2y2;
  logic signed [2*SQ_W-1:0]        p_xy3;
  logic signed [2*SQ_W-1:0]        p_y4;

  assign dx_in = DIFF_W'($signed(in_data[COORD_W-1:0])) - DIFF_W'(x_mean);
  assign dy_in = DIFF_W'($signed(in_data[2*COORD_W-1:COORD_W])) - DIFF_W'(y_mean);

  assign p_x3   = x2 * dx_d;
  assign p_x2y  = x2 * dy_d;
  assign p_xy2  = y2 * dx_d;
  assign p_y3   = y2 * dy_d;
  assign p_x4   = x2 * x2;
  assign p_x3y  = x2 * xy;
  assign p_x2y2 = x2 * y2;
  assign p_xy3  = y2 * xy;
  assign p_y4   = y2 * y2;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_mean <= '0;
      y_mean <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_X_MEAN) begin
        x_mean <= cfg_data;
      end
      if (cfg_index == REG_Y_MEAN) begin
        y_mean <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx        <= dx_in;
      dy        <= dy_in;
      last_flag <= in_last;
    end
    if (cmd.square) begin
      x2   <= dx * dx;
      y2   <= dy * dy;
      xy   <= dx * dy;
      dx_d <= dx;
      dy_d <= dy;
    end
    if (cmd.cube) begin
      terms[0]  <= p_x4[SUM_W-1:0];
      terms[1]  <= p_x3y[SUM_W-1:0];
      terms[2]  <= p_x2y2[SUM_W-1:0];
      terms[3]  <= SUM_W'(p_x3);
      terms[4]  <= SUM_W'(p_x2y);
      terms[5]  <= SUM_W'(x2);
      terms[6]  <= p_xy3[SUM_W-1:0];
      terms[7]  <= SUM_W'(p_xy2);
      terms[8]  <= SUM_W'(xy);
      terms[9]  <= p_y4[SUM_W-1:0];
      terms[10] <= SUM_W'(p_y3);
      terms[11] <= SUM_W'(y2);
      terms[12] <= SUM_W'(dx_d);
      terms[13] <= SUM_W'(dy_d);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SUMS; i++) begin
        sums[i] <= '0;
      end
      point_count <= '0;
      slot        <= '0;
    end else if (cmd.accum) begin
      for (int i = 0; i < NUM_SUMS; i++) begin
        sums[i] <= sums[i] + terms[i];
      end
      if (point_count < MAX_POINTS) begin
        point_count <= point_count + 1'b1;
      end
    end else if (cmd.advance) begin
      if (slot == COUNT_SLOT) begin
        for (int i = 0; i < NUM_SUMS; i++) begin
          sums[i] <= '0;
        end
        point_count <= '0;
        slot        <= '0;
      end else begin
        slot <= slot + 1'b1;
      end
    end
  end

  assign entry_index = slot;
  assign entry_value = (slot == COUNT_SLOT) ? SUM_W'(point_count) :
                                              sums[SLOT_SOURCE[slot]];

  assign status.last_point = last_flag;
  assign status.final_slot = (slot == COUNT_SLOT);

endmodule

FILE: rtl/csma_controller.sv
// Controller: sequences one point through the datapath and the result readout.
`timescale 1ns / 1ps

module csma_controller (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  csma_pkg::csma_status_t    status,
  output csma_pkg::csma_cmd_t       cmd
);
  import csma_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SQUARE = 5'b00010,
    ST_CUBE   = 5'b00100,
    ST_ACCUM  = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: state_next = ST_CUBE;
      ST_CUBE:   state_next = ST_ACCUM;
      ST_ACCUM:  state_next = status.last_point ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (out_ready && status.final_slot) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  assign in_ready    = (state == ST_IDLE);
  assign out_valid   = (state == ST_EMIT);
  assign cmd.load    = in_valid && (state == ST_IDLE);
  assign cmd.square  = (state == ST_SQUARE);
  assign cmd.cube    = (state == ST_CUBE);
  assign cmd.accum   = (state == ST_ACCUM);
  assign cmd.advance = out_ready && (state == ST_EMIT);

endmodule

FILE: rtl/conic_scatter_matrix_accumulator.sv
// Top level: streaming conic-fit scatter matrix moment accumulator.
// Each point passes through the input transfer, the square products, the higher products
// and the 64-bit accumulate before the next point can be taken.
// A point marked last is followed by 21 output transfers, the first offered after its
// accumulate, one per cycle while the sink is ready; then the sums and count clear.
// Synchronous reset clears the means, the sums, the point count and the controller.
`timescale 1ns / 1ps

module conic_scatter_matrix_accumulator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [csma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csma_pkg::COORD_W-1:0]    cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [csma_pkg::IN_DATA_W-1:0]  s_tdata,   // x_coord, y_coord
  input  logic                            s_tlast,   // last_point
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [csma_pkg::OUT_DATA_W-1:0] m_tdata,   // entry_index, entry_value, zero pad
  output logic                            m_tlast    // last_entry
);
  import csma_pkg::*;

  csma_cmd_t          cmd;
  csma_status_t       status;
  logic [SLOT_W-1:0]  entry_index;
  logic [SUM_W-1:0]   entry_value;

  csma_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  csma_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_data     (s_tdata),
    .in_last     (s_tlast),
    .cmd         (cmd),
    .status      (status),
    .entry_index (entry_index),
    .entry_value (entry_value)
  );

  assign m_tdata = {{(OUT_DATA_W - SUM_W - SLOT_W){1'b0}}, entry_value, entry_index};
  assign m_tlast = status.final_slot;

endmodule
